@@ rtl/lpfsr_pkg.sv @@
// Package for the lidar packet framer and speed regulator.
// Holds the framing constants, reset values, command and register codes and the
// angle table write word. No dependencies.
package lpfsr_pkg;

  localparam int WINDOW_DEPTH_DEF = 23;
  localparam int ANGLE_COUNT_DEF  = 360;

  localparam logic [7:0]  SYNC_BYTE   = 8'hFA;
  localparam logic [7:0]  INDEX_FIRST = 8'hA0;
  localparam logic [7:0]  INDEX_LAST  = 8'hF9;
  localparam logic [7:0]  DUTY_MAX    = 8'd255;
  localparam logic [15:0] SPEED_LOW_RST  = 16'h4B00;
  localparam logic [15:0] SPEED_HIGH_RST = 16'h4B50;
  localparam logic [7:0]  DIST_BAD_MASK  = 8'h80;
  localparam logic [7:0]  DIST_HI_MASK   = 8'h3F;
  localparam logic [7:0]  FLAG_MASK      = 8'hC0;

  // four readings of one packet share one table row
  localparam int ROW_ADDR_W = 7;
  localparam int ROW_DATA_W = 128;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SPEED    = 2'd0,
    KIND_DISTANCE = 2'd1,
    KIND_STRENGTH = 2'd2,
    KIND_FLAGS    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_MOTOR_ENABLE = 2'd0,
    REG_SPEED_LOW    = 2'd1,
    REG_SPEED_HIGH   = 2'd2
  } reg_e;

  typedef struct packed {
    logic                  en;
    logic [ROW_ADDR_W-1:0] row;
    logic [ROW_DATA_W-1:0] data;
  } row_wr_t;

endpackage

@@ rtl/lpfsr_angle_mem.sv @@
// Angle table: one row of four 32-bit readings per packet index, with a valid
// bit per row so that unwritten rows read as zero. Depends on lpfsr_pkg.
module lpfsr_angle_mem #(
  parameter int ANGLE_COUNT = lpfsr_pkg::ANGLE_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lpfsr_pkg::row_wr_t                  wr_i,
  input  logic                                rd_en_i,
  input  logic [lpfsr_pkg::ROW_ADDR_W-1:0]    rd_row_i,
  output logic [lpfsr_pkg::ROW_DATA_W-1:0]    rd_data_o
);
  import lpfsr_pkg::*;

  localparam int ROWS  = (ANGLE_COUNT + 3) / 4;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_ADDR_W-1:0] ROWS_LIM = ROW_ADDR_W'(ROWS);

  logic [ROW_DATA_W-1:0] mem_q [ROWS];
  logic [ROWS-1:0]       row_vld_q;
  logic [ROW_DATA_W-1:0] rd_data_q;
  logic                  rd_vld_q;
  logic                  wr_hit;
  logic                  rd_hit;
  logic [ROW_W-1:0]      wr_idx;
  logic [ROW_W-1:0]      rd_idx;

  assign wr_hit = wr_i.en && (wr_i.row < ROWS_LIM);
  assign rd_hit = rd_en_i && (rd_row_i < ROWS_LIM);
  assign wr_idx = wr_i.row[ROW_W-1:0];
  assign rd_idx = rd_row_i[ROW_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem_q[wr_idx] <= wr_i.data;
    end
    if (rd_hit) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_hit) begin
        row_vld_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= rd_hit && row_vld_q[rd_idx];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

@@ rtl/lidar_packet_framer_speed_regulator_top.sv @@
// Top level of the lidar packet framer and speed regulator: byte window,
// packet detection, duty regulation, APB registers and the read pipeline.
// Depends on lpfsr_pkg and lpfsr_angle_mem.
//
//  channel | direction | handshake              | word
//  in      | input     | in_valid_i / in_stall_o  | command, rx_byte, read_kind, read_angle
//  out     | output    | out_valid_o / out_stall_i| motor_duty, packet_taken, read_value, fresh
//  cfg     | input     | APB psel/penable/pready  | motor_enable, speed_low, speed_high
//
// One word a cycle while the output does not stall; the result of a word passes two
// register stages: the angle table read and the output register. Reset clears all
// state but the pipeline data registers, the angle table by its row valid bits, so
// words are taken from the first cycle after reset. A stalled output holds the
// pipeline and, once both stages are full, stalls the input in the same cycle.
module lidar_packet_framer_speed_regulator_top #(
  parameter int WINDOW_DEPTH = lpfsr_pkg::WINDOW_DEPTH_DEF,
  parameter int ANGLE_COUNT  = lpfsr_pkg::ANGLE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [1:0]  read_kind_i,
  input  logic [8:0]  read_angle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  motor_duty_o,
  output logic        packet_taken_o,
  output logic [15:0] read_value_o,
  output logic        fresh_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpfsr_pkg::*;

  localparam logic [8:0] ANGLE_LIM = 9'(ANGLE_COUNT);

  // configuration
  logic        enable_q;
  logic [15:0] speed_low_q;
  logic [15:0] speed_high_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // state
  logic [7:0]  win_q [WINDOW_DEPTH];
  logic [7:0]  win_d [WINDOW_DEPTH];
  logic [15:0] speed_q;
  logic [15:0] speed_d;
  logic [7:0]  duty_q;
  logic [7:0]  duty_d;
  logic        flag_q;
  logic        flag_d;

  // handshake
  logic in_acc;
  logic s1_adv;
  logic is_byte;
  logic is_read;
  logic take;
  logic [ROW_ADDR_W-1:0] row_idx;

  row_wr_t row_wr;
  logic [ROW_DATA_W-1:0] rd_row_data;

  // stage 1
  logic        s1_valid_q;
  logic        s1_read_q;
  logic [1:0]  s1_kind_q;
  logic [1:0]  s1_lane_q;
  logic        s1_angle_ok_q;
  logic [15:0] s1_speed_q;
  logic [7:0]  s1_duty_q;
  logic        s1_taken_q;
  logic        s1_fresh_q;

  // output stage
  logic        out_valid_q;
  logic [7:0]  out_duty_q;
  logic        out_taken_q;
  logic [15:0] out_value_q;
  logic        out_fresh_q;
  logic [15:0] value_d;
  logic [31:0] entry;
  logic [7:0]  b0, b1, b2, b3;

  // APB
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_MOTOR_ENABLE: prdata = {31'd0, enable_q};
      REG_SPEED_LOW:    prdata = {16'd0, speed_low_q};
      REG_SPEED_HIGH:   prdata = {16'd0, speed_high_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      speed_low_q  <= SPEED_LOW_RST;
      speed_high_q <= SPEED_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MOTOR_ENABLE: enable_q     <= pwdata[0];
        REG_SPEED_LOW:    speed_low_q  <= pwdata[15:0];
        REG_SPEED_HIGH:   speed_high_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_read    = (command_i == CMD_READ);
  assign is_byte    = in_acc && !is_read && enable_q;

  // window: oldest byte at index 0, newest at the top
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WINDOW_DEPTH-1] = rx_byte_i;
  end

  assign take = is_byte && (win_d[0] == SYNC_BYTE) && (win_d[WINDOW_DEPTH-1] == SYNC_BYTE)
                && (win_d[1] >= INDEX_FIRST) && (win_d[1] <= INDEX_LAST);
  assign row_idx = ROW_ADDR_W'(win_d[1] - INDEX_FIRST);

  always_comb begin
    row_wr.en  = take;
    row_wr.row = row_idx;
    for (int k = 0; k < 4; k++) begin
      row_wr.data[32*k +: 32] = {win_d[4*k+7], win_d[4*k+6], win_d[4*k+5], win_d[4*k+4]};
    end
  end

  always_comb begin
    speed_d = speed_q;
    duty_d  = duty_q;
    flag_d  = flag_q;
    if (take) begin
      speed_d = {win_d[3], win_d[2]};
      flag_d  = 1'b1;
      if (speed_d < speed_low_q) begin
        if (duty_q != DUTY_MAX) duty_d = duty_q + 8'd1;
      end else if (speed_d > speed_high_q) begin
        if (duty_q != 8'd0) duty_d = duty_q - 8'd1;
      end
    end
    if (in_acc && is_read) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= '0;
      end
      speed_q <= '0;
      duty_q  <= DUTY_MAX;
      flag_q  <= 1'b0;
    end else begin
      if (is_byte) begin
        win_q <= win_d;
      end
      speed_q <= speed_d;
      flag_q  <= flag_d;
      if (cfg_wr && (cfg_idx == REG_MOTOR_ENABLE) && pwdata[0] && !enable_q) begin
        duty_q <= DUTY_MAX;
      end else begin
        duty_q <= duty_d;
      end
    end
  end

  lpfsr_angle_mem #(
    .ANGLE_COUNT(ANGLE_COUNT)
  ) u_angle_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (row_wr),
    .rd_en_i  (in_acc && is_read),
    .rd_row_i (read_angle_i[8:2]),
    .rd_data_o(rd_row_data)
  );

  // stage 1: snapshot the word's state while the table is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_read_q     <= is_read;
      s1_kind_q     <= read_kind_i;
      s1_lane_q     <= read_angle_i[1:0];
      s1_angle_ok_q <= read_angle_i < ANGLE_LIM;
      s1_speed_q    <= speed_q;
      s1_duty_q     <= enable_q ? duty_d : 8'd0;
      s1_taken_q    <= take;
      s1_fresh_q    <= is_read && flag_q;
    end
  end

  assign entry = rd_row_data[32*s1_lane_q +: 32];
  assign b0 = entry[7:0];
  assign b1 = entry[15:8];
  assign b2 = entry[23:16];
  assign b3 = entry[31:24];

  always_comb begin
    value_d = '0;
    if (s1_read_q) begin
      case (s1_kind_q)
        KIND_SPEED: value_d = s1_speed_q;
        KIND_DISTANCE: begin
          if (s1_angle_ok_q && ((b1 & DIST_BAD_MASK) == 8'd0)) value_d = {b1 & DIST_HI_MASK, b0};
        end
        KIND_STRENGTH: begin
          if (s1_angle_ok_q) value_d = {b3, b2};
        end
        KIND_FLAGS: begin
          if (s1_angle_ok_q) value_d = {8'd0, b1 & FLAG_MASK};
        end
        default: value_d = '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_duty_q  <= s1_duty_q;
      out_taken_q <= s1_taken_q;
      out_value_q <= value_d;
      out_fresh_q <= s1_fresh_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motor_duty_o   = out_duty_q;
  assign packet_taken_o = out_taken_q;
  assign read_value_o   = out_value_q;
  assign fresh_o        = out_fresh_q;

endmodule
